// ----- sv/fpu_operand_format_converter_unit_assert.svh -----
// ----------------------------------------------------------------------------
// FPU operand converter assertion macros
// Concurrent assertion forms for the converter unit.
// ----------------------------------------------------------------------------
`ifndef FPU_OPERAND_FORMAT_CONVERTER_UNIT_ASSERT_SVH
`define FPU_OPERAND_FORMAT_CONVERTER_UNIT_ASSERT_SVH

// Implication checked every clock outside reset.
`define FOC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following clock.
`define FOC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/foc_pkg.sv -----
// ----------------------------------------------------------------------------
// FPU operand converter package
// Format codes and word layout shared by the converter files.
// ----------------------------------------------------------------------------
package foc_pkg;

  typedef enum logic [2:0] {
    FMT_LONG   = 3'd0,
    FMT_SINGLE = 3'd1,
    FMT_EXT    = 3'd2,
    FMT_PACKED = 3'd3,
    FMT_WORD   = 3'd4,
    FMT_DOUBLE = 3'd5,
    FMT_BYTE   = 3'd6,
    FMT_NONE   = 3'd7
  } fmt_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [2:0]  format;
    logic [31:0] mem_word0;
    logic [31:0] mem_word1;
    logic [31:0] mem_word2;
    logic [63:0] store_value;
  } req_t;

  typedef struct packed {
    logic [63:0] load_value;
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [31:0] out_word2;
    logic [3:0]  write_bytes;
  } rsp_t;

  localparam logic [63:0] QNAN64 = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] INF64  = 64'h7FF0_0000_0000_0000;

  // Position of the leading one (0 for zero).
  function automatic logic [5:0] lead64(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Round to nearest even after a right shift by s (s up to 127).
  function automatic logic [63:0] rne(input logic [63:0] x, input logic [6:0] s);
    logic [127:0] w;
    logic [63:0]  q;
    logic         g;
    logic         st;
    w = {x, 64'd0} >> s;
    q = w[127:64];
    g = w[63];
    st = |w[62:0];
    if (s == 7'd0) return x;
    if (s >= 7'd64) begin
      if (s == 7'd64) return {63'd0, x[63] & (|x[62:0])};
      return '0;
    end
    return q + {63'd0, g & (st | q[0])};
  endfunction

endpackage

// ----- sv/foc_if.sv -----
// ----------------------------------------------------------------------------
// FPU operand converter channel
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
interface foc_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/fpu_operand_format_converter_unit.sv -----
// ----------------------------------------------------------------------------
// FPU operand format converter
// Converts memory operands to IEEE double and double back to memory words.
// ----------------------------------------------------------------------------
// Each word passes two registers (input register, result register) and
// the block accepts one word every cycle; a full result register that is not
// taken stalls the input side, with the input register as a second stage.
// Loads (func 0) give a double in load_value; stores (func 1) give up to
// three longwords in out_word0..2 with the byte count in write_bytes.
`include "fpu_operand_format_converter_unit_assert.svh"
module fpu_operand_format_converter_unit import foc_pkg::*; (
  input logic    clk,
  input logic    rst,
  foc_if.sink    in_ch,
  foc_if.source  out_ch
);

  req_t        req;
  logic        req_valid;
  rsp_t        rsp;
  logic        rsp_valid;
  logic [63:0] lval;
  logic [31:0] sw0;
  logic [31:0] sw1;
  logic [31:0] sw2;
  logic [3:0]  snb;
  rsp_t        rsp_next;
  logic        adv;

  // advance the input stage when the result register is free or draining
  assign adv = !rsp_valid || out_ch.ready;
  assign in_ch.ready = !req_valid || adv;

  foc_load u_load (.req(req), .value(lval));
  foc_store u_store (.req(req), .w0(sw0), .w1(sw1), .w2(sw2), .nb(snb));

  always_comb begin
    rsp_next = '0;
    if (req.func == FUNC_LOAD) begin
      rsp_next.load_value = lval;
    end else begin
      rsp_next.out_word0 = sw0;
      rsp_next.out_word1 = sw1;
      rsp_next.out_word2 = sw2;
      rsp_next.write_bytes = snb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (in_ch.ready) req_valid <= in_ch.valid;
      if (adv) rsp_valid <= req_valid;
    end
    if (in_ch.ready && in_ch.valid) req <= in_ch.data;
    if (adv && req_valid) rsp <= rsp_next;
  end

  assign out_ch.valid = rsp_valid;
  assign out_ch.data = rsp;

  `FOC_ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !out_ch.ready, rsp_valid && $stable(rsp), "result dropped while stalled")
  `FOC_ASSERT_IMPL(a_load_nb, clk, rst, rsp_valid && rsp.load_value != 64'd0, rsp.write_bytes == 4'd0, "load with write bytes")
  `FOC_ASSERT_IMPL(a_ready, clk, rst, req_valid && rsp_valid && !out_ch.ready, !in_ch.ready, "accept while full")

endmodule

// ----- sv/foc_load.sv -----
// ----------------------------------------------------------------------------
// FPU operand converter load path
// Memory operand words to IEEE double.
// ----------------------------------------------------------------------------
module foc_load import foc_pkg::*; (
  input  req_t        req,
  output logic [63:0] value
);

  logic [31:0]  iraw;
  logic [31:0]  imag;
  logic [5:0]   ip;
  logic [63:0]  ival;
  logic [63:0]  sval;
  logic [63:0]  xval;
  logic [5:0]   sp;
  logic [63:0]  m;
  logic [5:0]   xp;
  logic [63:0]  sig;
  logic signed [17:0] ue;
  logic signed [17:0] b;

  always_comb begin
    // integers
    unique case (req.format)
      FMT_WORD: iraw = {{16{req.mem_word0[15]}}, req.mem_word0[15:0]};
      FMT_BYTE: iraw = {{24{req.mem_word0[7]}}, req.mem_word0[7:0]};
      default:  iraw = req.mem_word0;
    endcase
    imag = iraw[31] ? (~iraw + 32'd1) : iraw;
    ip = lead64({32'd0, imag});
    ival = '0;
    if (imag != 32'd0) begin
      ival = {iraw[31], 11'(ip + 6'd0) + 11'd1023,
              52'(({32'd0, imag} << (7'd52 - 7'(ip))))};
    end

    // single
    sp = lead64({41'd0, req.mem_word0[22:0]});
    if (req.mem_word0[30:23] == 8'hFF) begin
      if (req.mem_word0[22:0] == 23'd0) sval = {req.mem_word0[31], 63'd0} | INF64;
      else sval = {req.mem_word0[31], 63'd0} | QNAN64 | {12'd0, req.mem_word0[22:0], 29'd0};
    end else if (req.mem_word0[30:23] == 8'd0) begin
      if (req.mem_word0[22:0] == 23'd0) sval = {req.mem_word0[31], 63'd0};
      else sval = {req.mem_word0[31], 11'(sp) + 11'd874,
                   52'({41'd0, req.mem_word0[22:0]} << (7'd52 - 7'(sp)))};
    end else begin
      sval = {req.mem_word0[31], 11'(req.mem_word0[30:23]) + 11'd896,
              req.mem_word0[22:0], 29'd0};
    end

    // extended
    m = {req.mem_word1, req.mem_word2};
    xp = lead64(m);
    if (xp > 6'd52) begin
      sig = rne(m, 7'(xp - 6'd52));
    end else begin
      sig = m << (7'd52 - 7'(xp));
    end
    ue = 18'(req.mem_word0[30:16]) - 18'sd16446 + 18'(xp);
    if (sig[53]) begin
      sig = sig >> 1;
      ue = ue + 18'sd1;
    end
    b = ue + 18'sd1023;
    if (req.mem_word0[30:16] == 15'h7FFF) begin
      xval = (m == 64'd0) ? ({req.mem_word0[31], 63'd0} | INF64) : QNAN64;
    end else if (m == 64'd0) begin
      xval = {req.mem_word0[31], 63'd0};
    end else if (b >= 18'sd2047) begin
      xval = {req.mem_word0[31], 63'd0} | INF64;
    end else if (b >= 18'sd1) begin
      xval = {req.mem_word0[31], b[10:0], sig[51:0]};
    end else begin
      xval = {req.mem_word0[31], 63'd0} |
             rne(sig, (b < -18'sd125) ? 7'd127 : 7'(18'sd1 - b));
    end

    unique case (req.format)
      FMT_LONG, FMT_WORD, FMT_BYTE: value = ival;
      FMT_SINGLE: value = sval;
      FMT_EXT:    value = xval;
      FMT_PACKED: value = {req.mem_word0[31], 63'd0};
      FMT_DOUBLE: value = {req.mem_word0, req.mem_word1};
      default:    value = '0;
    endcase
  end

endmodule

// ----- sv/foc_store.sv -----
// ----------------------------------------------------------------------------
// FPU operand converter store path
// IEEE double to memory operand words.
// ----------------------------------------------------------------------------
module foc_store import foc_pkg::*; (
  input  req_t        req,
  output logic [31:0] w0,
  output logic [31:0] w1,
  output logic [31:0] w2,
  output logic [3:0]  nb
);

  logic        sg;
  logic [10:0] e;
  logic [51:0] fr;
  logic [52:0] sig;
  logic [5:0]  s;
  logic [52:0] mag;
  logic        nan;
  logic        big;
  logic        tiny;
  logic [31:0] ilong;
  logic [31:0] iword;
  logic [31:0] ibyte;
  logic [63:0] q;
  logic signed [12:0] fb;
  logic [31:0] sgl;
  logic [5:0]  p;
  logic [14:0] xe;
  logic [63:0] xm;

  always_comb begin
    sg = req.store_value[63];
    e = req.store_value[62:52];
    fr = req.store_value[51:0];
    sig = {1'b1, fr};
    nan = (e == 11'h7FF) && (fr != 52'd0);
    big = (e == 11'h7FF) || (e >= 11'd1063);
    tiny = e < 11'd1022;
    s = (e == 11'd1022) ? 6'd53 : 6'(11'd1075 - e);
    mag = (sig >> s) + 53'((sig >> (s - 6'd1)) & 53'd1);

    // saturate per width
    if (nan || tiny) ilong = '0;
    else if (big) ilong = sg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (sg) ilong = (mag > 53'd2147483648) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    else ilong = (mag > 53'd2147483647) ? 32'h7FFF_FFFF : mag[31:0];

    if (nan || tiny) iword = '0;
    else if (big) iword = sg ? 32'h8000 : 32'h7FFF;
    else if (sg) iword = (mag > 53'd32768) ? 32'h8000 : {16'd0, ~mag[15:0] + 16'd1};
    else iword = (mag > 53'd32767) ? 32'h7FFF : {16'd0, mag[15:0]};

    if (nan || tiny) ibyte = '0;
    else if (big) ibyte = sg ? 32'h80 : 32'h7F;
    else if (sg) ibyte = (mag > 53'd128) ? 32'h80 : {24'd0, ~mag[7:0] + 8'd1};
    else ibyte = (mag > 53'd127) ? 32'h7F : {24'd0, mag[7:0]};

    // single
    fb = 13'(e) - 13'sd896;
    if (e == 11'h7FF) begin
      sgl = (fr == 52'd0) ? {sg, 31'h7F80_0000} : {sg, 31'h7FC0_0000 | 31'(fr[51:29])};
      q = '0;
    end else if (e == 11'd0) begin
      sgl = {sg, 31'd0};
      q = '0;
    end else if (fb >= 13'sd1) begin
      q = rne({11'd0, sig}, 7'd29);
      if (q[24]) begin
        q = q >> 1;
        fb = fb + 13'sd1;
      end
      sgl = (fb >= 13'sd255) ? {sg, 31'h7F80_0000} : {sg, fb[7:0], q[22:0]};
    end else begin
      q = rne({11'd0, sig}, (fb < -13'sd90) ? 7'd127 : 7'(13'sd30 - fb));
      sgl = {sg, 31'(q)};
    end

    // extended
    p = lead64({12'd0, fr});
    if (e == 11'h7FF) begin
      xe = 15'h7FFF;
      xm = (fr != 52'd0) ? '1 : 64'h8000_0000_0000_0000;
    end else if (e == 11'd0 && fr == 52'd0) begin
      xe = '0;
      xm = '0;
    end else if (e == 11'd0) begin
      xe = 15'(p) + 15'd15309;
      xm = {12'd0, fr} << (7'd63 - 7'(p));
    end else begin
      xe = 15'(e) + 15'd15360;
      xm = {1'b1, fr, 11'd0};
    end

    w0 = '0;
    w1 = '0;
    w2 = '0;
    nb = '0;
    unique case (req.format)
      FMT_LONG: begin
        w0 = ilong;
        nb = 4'd4;
      end
      FMT_SINGLE: begin
        w0 = sgl;
        nb = 4'd4;
      end
      FMT_EXT: begin
        w0 = {sg, xe, 16'd0};
        w1 = xm[63:32];
        w2 = xm[31:0];
        nb = 4'd12;
      end
      FMT_WORD: begin
        w0 = iword;
        nb = 4'd2;
      end
      FMT_DOUBLE: begin
        w0 = req.store_value[63:32];
        w1 = req.store_value[31:0];
        nb = 4'd8;
      end
      FMT_BYTE: begin
        w0 = ibyte;
        nb = 4'd1;
      end
      default: ;
    endcase
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operand format converter testbench
// Drives load and store conversions through the valid/ready channels with
// random gaps and stalls, predicts each result word in a scoreboard and
// compares every field in order.
// ----------------------------------------------------------------------------
module tb;
  import foc_pkg::*;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] NAN_DBL = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] INF_DBL = 64'h7FF0_0000_0000_0000;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_RANDOM = 1525;

  // Shift right, rounding to nearest even.
  function automatic logic [63:0] round_shift(logic [63:0] x, int unsigned s);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    if (s == 0) return x;
    if (s >= 64) return '0;
    q = x >> s;
    rem = x & ((64'd1 << s) - 1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    return q;
  endfunction

  function automatic int unsigned msb_pos(logic [63:0] x);
    int unsigned p;
    p = 0;
    for (int i = 0; i < 64; i++) if (x[i]) p = i;
    return p;
  endfunction

  // Exact integer magnitude to double.
  function automatic logic [63:0] int_to_dbl(logic neg, logic [63:0] mag);
    int unsigned p;
    logic [63:0] r;
    if (mag == 0) return '0;
    p = msb_pos(mag);
    r = (64'(p + 1023) << 52) | ((mag << (52 - p)) & FRAC_MASK);
    if (neg) r |= SIGN_BIT;
    return r;
  endfunction

  function automatic logic [63:0] ext_load(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2);
    logic [63:0] sgn;
    logic [63:0] m;
    logic [63:0] sig;
    int ex;
    int ue;
    int biased;
    int unsigned p;
    sgn = {w0[31], 63'd0};
    ex = int'(w0[30:16]);
    m = {w1, w2};
    if (ex == 'h7FFF) return (m == 0) ? (sgn | INF_DBL) : NAN_DBL;
    if (m == 0) return sgn;
    p = msb_pos(m);
    ue = ex - 16383 - 63 + int'(p);
    if (p > 52) begin
      sig = round_shift(m, p - 52);
      if (sig == (64'd1 << 53)) begin
        sig = sig >> 1;
        ue++;
      end
    end else begin
      sig = m << (52 - p);
    end
    biased = ue + 1023;
    if (biased >= 2047) return sgn | INF_DBL;
    if (biased >= 1) return sgn | (64'(biased) << 52) | (sig & FRAC_MASK);
    return sgn | round_shift(sig, 1 - biased);
  endfunction

  function automatic logic [63:0] sgl_load(logic [31:0] f);
    logic [63:0] sgn;
    logic [63:0] fr;
    int unsigned p;
    sgn = {f[31], 63'd0};
    fr = 64'(f[22:0]);
    if (f[30:23] == 8'hFF) begin
      if (fr == 0) return sgn | INF_DBL;
      return sgn | NAN_DBL | (fr << 29);
    end
    if (f[30:23] == 0) begin
      if (fr == 0) return sgn;
      p = msb_pos(fr);
      return sgn | (64'(p + 874) << 52) | ((fr << (52 - p)) & FRAC_MASK);
    end
    return sgn | (64'(int'(f[30:23]) + 896) << 52) | (fr << 29);
  endfunction

  function automatic logic [31:0] sgl_store(logic [63:0] d);
    logic [31:0] sgn;
    logic [63:0] sig;
    logic [63:0] q;
    int fb;
    sgn = {d[63], 31'd0};
    if (d[62:52] == 11'h7FF) begin
      if (d[51:0] == 0) return sgn | 32'h7F80_0000;
      return sgn | 32'h7FC0_0000 | 32'(d[51:29]);
    end
    if (d[62:52] == 0) return sgn;
    sig = {11'd1, d[51:0]};
    fb = int'(d[62:52]) - 896;
    if (fb >= 1) begin
      q = round_shift(sig, 29);
      if (q == (64'd1 << 24)) begin
        q = q >> 1;
        fb++;
      end
      if (fb >= 255) return sgn | 32'h7F80_0000;
      return sgn | (32'(fb) << 23) | 32'(q[22:0]);
    end
    q = round_shift(sig, 30 - fb);
    return sgn | q[31:0];
  endfunction

  // Half-away rounding with saturation; NaN gives 0.
  function automatic longint dbl_to_int(logic [63:0] d, longint lo, longint hi);
    int unsigned e;
    int unsigned s;
    logic [63:0] sig;
    logic [63:0] mag;
    e = d[62:52];
    if (e == 'h7FF) begin
      if (d[51:0] != 0) return 0;
      return d[63] ? lo : hi;
    end
    if (e < 1022) return 0;
    if (e >= 1063) return d[63] ? lo : hi;
    sig = {11'd1, d[51:0]};
    s = (e == 1022) ? 53 : 52 - (e - 1023);
    mag = (sig >> s) + ((sig >> (s - 1)) & 1);
    if (d[63]) begin
      if (mag > 64'(-lo)) return lo;
      return -longint'(mag);
    end
    if (mag > 64'(hi)) return hi;
    return longint'(mag);
  endfunction

  function automatic rsp_t convert(req_t r);
    rsp_t o;
    logic [63:0] v;
    logic [63:0] m;
    logic [63:0] ex;
    logic [63:0] raw;
    int unsigned p;
    o = '0;
    v = r.store_value;
    if (r.func == FUNC_LOAD) begin
      case (fmt_t'(r.format))
        FMT_LONG: o.load_value = int_to_dbl(r.mem_word0[31],
            r.mem_word0[31] ? 64'(-r.mem_word0) & 64'hFFFF_FFFF : 64'(r.mem_word0));
        FMT_SINGLE: o.load_value = sgl_load(r.mem_word0);
        FMT_EXT: o.load_value = ext_load(r.mem_word0, r.mem_word1, r.mem_word2);
        FMT_PACKED: o.load_value = {r.mem_word0[31], 63'd0};
        FMT_WORD: begin
          raw = 64'(r.mem_word0[15:0]);
          o.load_value = int_to_dbl(raw[15], raw[15] ? 64'h1_0000 - raw : raw);
        end
        FMT_BYTE: begin
          raw = 64'(r.mem_word0[7:0]);
          o.load_value = int_to_dbl(raw[7], raw[7] ? 64'h100 - raw : raw);
        end
        FMT_DOUBLE: o.load_value = {r.mem_word0, r.mem_word1};
        default: o.load_value = '0;
      endcase
    end else begin
      case (fmt_t'(r.format))
        FMT_LONG: begin
          o.out_word0 = 32'(dbl_to_int(v, -64'sd2147483648, 64'sd2147483647));
          o.write_bytes = 4;
        end
        FMT_SINGLE: begin
          o.out_word0 = sgl_store(v);
          o.write_bytes = 4;
        end
        FMT_EXT: begin
          if (v[62:52] == 11'h7FF) begin
            ex = 'h7FFF;
            m = (v[51:0] != 0) ? '1 : SIGN_BIT;
          end else if (v[62:0] == 0) begin
            ex = 0;
            m = 0;
          end else if (v[62:52] == 0) begin
            p = msb_pos(v & FRAC_MASK);
            ex = 64'(p + 15309);
            m = (v & FRAC_MASK) << (63 - p);
          end else begin
            ex = 64'(v[62:52]) + 15360;
            m = SIGN_BIT | ((v & FRAC_MASK) << 11);
          end
          o.out_word0 = {v[63], ex[14:0], 16'd0};
          o.out_word1 = m[63:32];
          o.out_word2 = m[31:0];
          o.write_bytes = 12;
        end
        FMT_WORD: begin
          o.out_word0 = {16'd0, 16'(dbl_to_int(v, -32768, 32767))};
          o.write_bytes = 2;
        end
        FMT_DOUBLE: begin
          o.out_word0 = v[63:32];
          o.out_word1 = v[31:0];
          o.write_bytes = 8;
        end
        FMT_BYTE: begin
          o.out_word0 = {24'd0, 8'(dbl_to_int(v, -128, 127))};
          o.write_bytes = 1;
        end
        default: ;
      endcase
    end
    return o;
  endfunction

  class conv_scoreboard;
    rsp_t pending[$];
    int mismatches;

    function void note_word(req_t r);
      pending.push_back(convert(r));
    endfunction

    function void check_word(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.load_value !== want.load_value || got.out_word0 !== want.out_word0 ||
          got.out_word1 !== want.out_word1 || got.out_word2 !== want.out_word2 ||
          got.write_bytes !== want.write_bytes) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: lv %h/%h w0 %h/%h w1 %h/%h w2 %h/%h nb %0d/%0d (exp/act)",
                   want.load_value, got.load_value, want.out_word0, got.out_word0,
                   want.out_word1, got.out_word1, want.out_word2, got.out_word2,
                   want.write_bytes, got.write_bytes);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned cycles = 0;
  bit stim_done = 1'b0;
  conv_scoreboard sb = new();

  foc_if #(.T(req_t)) in_ch ();
  foc_if #(.T(rsp_t)) out_ch ();

  fpu_operand_format_converter_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Mostly short gaps, now and then a long one, with gap-free stretches.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Note each accepted word and check each taken result at the edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_word(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_word(out_ch.data);
    end
  end

  // Receiver: toggle ready with random stalls; hold ready low during reset.
  initial begin
    int unsigned g;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // Present one word and hold it until accepted; drop valid only for a gap before it.
  task automatic send_word(req_t r);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_op(logic f, fmt_t fm, logic [31:0] a, logic [31:0] b,
                         logic [31:0] c, logic [63:0] v);
    req_t r;
    r.func = f;
    r.format = fm;
    r.mem_word0 = a;
    r.mem_word1 = b;
    r.mem_word2 = c;
    r.store_value = v;
    send_word(r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Interesting doubles: near integer boundaries, tiny, huge, specials.
  function automatic logic [63:0] pick_double();
    logic [63:0] d;
    d = rand64();
    case ($urandom_range(0, 7))
      0: d[62:52] = 11'(1020 + $urandom_range(0, 45));
      1: d[62:52] = 11'(1016 + $urandom_range(0, 12));
      2: d[62:52] = 11'(870 + $urandom_range(0, 30));
      3: d[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
      4: d[62:52] = 11'(1144 + $urandom_range(0, 10));
      5: d[51:0] = {$urandom_range(0, 1) ? 4'hF : 4'h0, 48'd0} | 52'($urandom_range(0, 3));
      default: ;
    endcase
    return d;
  endfunction

  task automatic send_random();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = $urandom();
    b = $urandom();
    c = $urandom();
    case ($urandom_range(0, 5))
      0: a[30:16] = 15'(16383 - 1100 + $urandom_range(0, 2200));
      1: a[30:16] = 15'(16383 + $urandom_range(0, 1) * 1024 - 1 + $urandom_range(0, 2));
      2: a[30:16] = $urandom_range(0, 1) ? 15'h7FFF : 15'h0;
      3: begin
        b = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
        c = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 2048));
      end
      4: if ($urandom_range(0, 1)) b = 0; else c = 0;
      default: ;
    endcase
    send_op(1'($urandom_range(0, 1)), fmt_t'($urandom_range(0, 7)), a, b, c, pick_double());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: integer, single, extended, packed, double and unused-format extremes, loads then stores.
    send_op(FUNC_LOAD, FMT_LONG, 32'h8000_0000, 0, 0, 0);
    send_op(FUNC_LOAD, FMT_WORD, 32'h0000_8000, 0, 0, 0);
    send_op(FUNC_LOAD, FMT_BYTE, 32'hFFFF_FF7F, 0, 0, 0);
    send_op(FUNC_LOAD, FMT_SINGLE, 32'hFFC0_0001, 0, 0, 0);
    send_op(FUNC_LOAD, FMT_SINGLE, 32'h8000_0001, 0, 0, 0);
    send_op(FUNC_LOAD, FMT_EXT, 32'hFFFF_0000, 32'h0, 32'h1, 0);
    send_op(FUNC_LOAD, FMT_EXT, 32'h7FFF_0000, 32'h0, 32'h0, 0);
    send_op(FUNC_LOAD, FMT_EXT, 32'h8123_0000, 32'h0, 32'h0, 0);
    send_op(FUNC_LOAD, FMT_EXT, 32'h43FE_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_op(FUNC_LOAD, FMT_EXT, 32'h3BCD_0000, 32'hC000_0000, 32'h0000_0400, 0);
    send_op(FUNC_LOAD, FMT_PACKED, 32'h8000_0000, 0, 0, 0);
    send_op(FUNC_LOAD, FMT_DOUBLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    send_op(FUNC_LOAD, FMT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_op(FUNC_STORE, FMT_LONG, 0, 0, 0, 64'h7FF8_0000_0000_0001);
    send_op(FUNC_STORE, FMT_LONG, 0, 0, 0, 64'hFFF0_0000_0000_0000);
    send_op(FUNC_STORE, FMT_WORD, 0, 0, 0, 64'h40DF_FFE0_0000_0000);
    send_op(FUNC_STORE, FMT_BYTE, 0, 0, 0, 64'hC060_1000_0000_0000);
    send_op(FUNC_STORE, FMT_BYTE, 0, 0, 0, 64'h3FE0_0000_0000_0000);
    send_op(FUNC_STORE, FMT_SINGLE, 0, 0, 0, 64'h47EF_FFFF_F000_0000);
    send_op(FUNC_STORE, FMT_SINGLE, 0, 0, 0, 64'h3690_0000_0000_0001);
    send_op(FUNC_STORE, FMT_SINGLE, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(FUNC_STORE, FMT_EXT, 0, 0, 0, 64'h8000_0000_0000_0001);
    send_op(FUNC_STORE, FMT_EXT, 0, 0, 0, 64'h7FF0_0000_0000_0000);
    send_op(FUNC_STORE, FMT_DOUBLE, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(FUNC_STORE, FMT_PACKED, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    // Hold the sender until every result has drained.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    for (int i = 0; i < NUM_RANDOM; i++) send_random();
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run: drain, let the pipeline settle, then report.
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Watchdog on the cycle counter.
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end
endmodule
